@@ src/nimh_pkg.sv @@
`default_nettype none

package nimh_pkg;

    localparam int unsigned START_STEP  = 10;
    localparam int unsigned REACH_STEP  = 2;
    localparam int unsigned LEVEL_COUNT = 11;
    localparam int unsigned DRIVE_CAP   = 3000;

    localparam int unsigned COMP_GAIN      = 70;
    localparam int unsigned COMP_SHIFT     = 7;
    localparam int unsigned GOAL_HI_MARGIN = 4;
    localparam int unsigned GOAL_LO_MARGIN = 2;
    localparam int unsigned DRIVE_MAX      = 4095;

    localparam int unsigned LEVEL_W = 4;
    localparam int unsigned IN_W    = 32;
    localparam int unsigned OUT_W   = 56;

    localparam logic [11:0] LEVEL_THR [LEVEL_COUNT] = '{
        12'd2300, 12'd2360, 12'd2400, 12'd2430, 12'd2460, 12'd2490,
        12'd2520, 12'd2550, 12'd2590, 12'd2640, 12'd2700
    };

    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_RAMP        = 3'd1,
        PH_REACH       = 3'd2,
        PH_MAINTAIN    = 3'd3,
        PH_DONE        = 3'd4,
        PH_RAMP_FAULT  = 3'd5,
        PH_MAINT_FAULT = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_START  = 2'd1,
        ACT_STOP   = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_FAIL  = 2'd1,
        EV_DONE  = 2'd2,
        EV_LEVEL = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        RA_NONE     = 2'd0,
        RA_START    = 2'd1,
        RA_REACH    = 2'd2,
        RA_MAINTAIN = 2'd3
    } t_rearm;

    typedef enum logic [2:0] {
        CFG_START_VOLTAGE   = 3'd0,
        CFG_RAMP_END_CUR    = 3'd1,
        CFG_RAMP_MAX_VOLT   = 3'd2,
        CFG_GOAL_HALF_C     = 3'd3,
        CFG_GOAL_2_3_C      = 3'd4,
        CFG_REACH_MAX_VOLT  = 3'd5,
        CFG_DROP_THRESHOLD  = 3'd6,
        CFG_PEAK_TIMEOUT    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [11:0] start_voltage;
        logic [11:0] ramp_end_current;
        logic [11:0] ramp_max_voltage;
        logic [11:0] goal_half_c;
        logic [11:0] goal_two_thirds_c;
        logic [11:0] reach_max_voltage;
        logic [11:0] drop_threshold;
        logic [15:0] peak_timeout_secs;
    } t_cfg;

    typedef struct packed {
        t_phase               phase;
        logic                 rate;
        logic [11:0]          drive;
        logic [11:0]          peak;
        logic [15:0]          secs;
        logic [5:0]           last_sec;
        logic [LEVEL_W-1:0]   level;
    } t_state;

    typedef struct packed {
        logic [1:0]  action;
        logic        charge_rate;
        logic [11:0] high_sense;
        logic [11:0] low_sense;
        logic        tick_due;
        logic [5:0]  second_now;
    } t_item;

    typedef struct packed {
        t_phase              phase;
        logic [11:0]         stepdown_setting;
        logic                charge_enable;
        t_event              event_code;
        logic [LEVEL_W-1:0]  battery_level;
        t_rearm              timer_rearm;
        logic signed [12:0]  sense_current;
        logic [11:0]         sense_vbat;
    } t_result;

endpackage

`default_nettype wire

@@ src/nimh_charge_controller_unit.sv @@
// The input register holds an accepted request; its result is worked out from
// there and shown from the result register once that register can take it.
// Throughput: one request per cycle while m_axis_tready is high; the input
// register takes one request while a finished result waits on m_axis_tready.
// Reset: synchronous, active low; clears the phase to idle, all charge state,
// the pipeline valid flags and restores the default register values.
`default_nettype none

module nimh_charge_controller_unit (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire [2:0]                  i_cfg_index,
    input  wire [15:0]                 i_cfg_wdata,
    input  wire                        s_axis_tvalid,
    output logic                       s_axis_tready,
    // charge_rate, high_sense, low_sense, tick_due, second_now
    input  wire [nimh_pkg::IN_W-1:0]   s_axis_tdata,
    // action
    input  wire [1:0]                  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire                        m_axis_tready,
    // phase, stepdown_setting, charge_enable, event_code, battery_level,
    // timer_rearm, sense_current, sense_vbat, zero fill
    output logic [nimh_pkg::OUT_W-1:0] m_axis_tdata
);

    nimh_pkg::t_cfg     r_cfg;
    nimh_pkg::t_state   r_state;
    nimh_pkg::t_state   n_state;
    nimh_pkg::t_item    r_item;
    nimh_pkg::t_result  n_result;
    nimh_pkg::t_result  r_result;
    logic               r_in_valid;
    logic               r_out_valid;
    logic               advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_result.sense_vbat, r_result.sense_current,
                            r_result.timer_rearm, r_result.battery_level,
                            r_result.event_code, r_result.charge_enable,
                            r_result.stepdown_setting, r_result.phase};

    nimh_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_voltage     <= 12'd1500;
            r_cfg.ramp_end_current  <= 12'd50;
            r_cfg.ramp_max_voltage  <= 12'd3000;
            r_cfg.goal_half_c       <= 12'd300;
            r_cfg.goal_two_thirds_c <= 12'd400;
            r_cfg.reach_max_voltage <= 12'd3000;
            r_cfg.drop_threshold    <= 12'd8;
            r_cfg.peak_timeout_secs <= 16'd1200;
        end else if (i_cfg_we) begin
            case (nimh_pkg::t_cfg_idx'(i_cfg_index))
                nimh_pkg::CFG_START_VOLTAGE:  r_cfg.start_voltage     <= i_cfg_wdata[11:0];
                nimh_pkg::CFG_RAMP_END_CUR:   r_cfg.ramp_end_current  <= i_cfg_wdata[11:0];
                nimh_pkg::CFG_RAMP_MAX_VOLT:  r_cfg.ramp_max_voltage  <= i_cfg_wdata[11:0];
                nimh_pkg::CFG_GOAL_HALF_C:    r_cfg.goal_half_c       <= i_cfg_wdata[11:0];
                nimh_pkg::CFG_GOAL_2_3_C:     r_cfg.goal_two_thirds_c <= i_cfg_wdata[11:0];
                nimh_pkg::CFG_REACH_MAX_VOLT: r_cfg.reach_max_voltage <= i_cfg_wdata[11:0];
                nimh_pkg::CFG_DROP_THRESHOLD: r_cfg.drop_threshold    <= i_cfg_wdata[11:0];
                nimh_pkg::CFG_PEAK_TIMEOUT:   r_cfg.peak_timeout_secs <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state.phase    <= nimh_pkg::PH_IDLE;
            r_state.rate     <= 1'b0;
            r_state.drive    <= '0;
            r_state.peak     <= '0;
            r_state.secs     <= '0;
            r_state.last_sec <= '0;
            r_state.level    <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item.action      <= s_axis_tuser;
            r_item.charge_rate <= s_axis_tdata[0];
            r_item.high_sense  <= s_axis_tdata[12:1];
            r_item.low_sense   <= s_axis_tdata[24:13];
            r_item.tick_due    <= s_axis_tdata[25];
            r_item.second_now  <= s_axis_tdata[31:26];
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

endmodule

`default_nettype wire

@@ src/nimh_step.sv @@
`default_nettype none

module nimh_step (
    input  wire nimh_pkg::t_cfg    i_cfg,
    input  wire nimh_pkg::t_state  i_state,
    input  wire nimh_pkg::t_item   i_item,
    output nimh_pkg::t_state       o_state,
    output nimh_pkg::t_result      o_result
);

    logic signed [12:0] cur;
    logic [11:0]        goal;
    logic [11:0]        lo;
    logic [11:0]        hi;
    logic [11:0]        peak_n;
    logic [11:0]        h_diff;
    logic [11:0]        drop;
    logic [11:0]        comp;
    logic [18:0]        prod;
    logic [11:0]        comp_inc;
    logic [3:0]         cand;
    nimh_pkg::t_state   st;
    nimh_pkg::t_event   ev;
    nimh_pkg::t_rearm   ra;
    logic               show_sense;

    // saturating raise of the step-down setting
    function automatic logic [11:0] drive_up(input logic [11:0] v, input logic [11:0] inc);
        logic [12:0] s;
        s = {1'b0, v} + {1'b0, inc};
        drive_up = (s > 13'(nimh_pkg::DRIVE_MAX)) ? 12'(nimh_pkg::DRIVE_MAX) : s[11:0];
    endfunction

    always_comb begin
        hi     = i_item.high_sense;
        lo     = i_item.low_sense;
        cur    = $signed({1'b0, hi}) - $signed({1'b0, lo});
        goal   = i_state.rate ? i_cfg.goal_two_thirds_c : i_cfg.goal_half_c;
        peak_n = (lo > i_state.peak) ? lo : i_state.peak;
        h_diff = (hi > lo) ? (hi - lo) : 12'd0;
        drop   = peak_n - lo;
        comp   = goal - h_diff;
        prod   = {7'd0, comp} * 19'(nimh_pkg::COMP_GAIN);
        comp_inc = 12'(prod >> nimh_pkg::COMP_SHIFT);

        cand = '0;
        for (int i = 0; i < nimh_pkg::LEVEL_COUNT; i++) begin
            if (lo > nimh_pkg::LEVEL_THR[i]) begin
                cand = 4'(i);
            end
        end

        st = i_state;
        ev = nimh_pkg::EV_NONE;
        ra = nimh_pkg::RA_NONE;
        show_sense = 1'b0;

        case (i_item.action)
            nimh_pkg::ACT_START: begin
                st.drive = i_cfg.start_voltage;
                st.phase = nimh_pkg::PH_RAMP;
                st.rate  = i_item.charge_rate;
                st.level = '0;
                st.secs  = '0;
                st.peak  = '0;
                ra = nimh_pkg::RA_START;
            end
            nimh_pkg::ACT_STOP: begin
                if (i_state.phase inside {nimh_pkg::PH_RAMP, nimh_pkg::PH_REACH,
                                          nimh_pkg::PH_MAINTAIN}) begin
                    st.phase = nimh_pkg::PH_IDLE;
                end
            end
            nimh_pkg::ACT_SAMPLE: begin
                show_sense = 1'b1;
                if (i_item.tick_due) begin
                    case (i_state.phase)
                        nimh_pkg::PH_RAMP: begin
                            if (cur > $signed({1'b0, i_cfg.ramp_end_current})) begin
                                st.phase = nimh_pkg::PH_REACH;
                                ra = nimh_pkg::RA_REACH;
                            end else begin
                                st.drive = drive_up(i_state.drive, 12'(nimh_pkg::START_STEP));
                                if (lo >= i_cfg.ramp_max_voltage) begin
                                    st.phase = nimh_pkg::PH_RAMP_FAULT;
                                    ev = nimh_pkg::EV_FAIL;
                                end
                            end
                        end
                        nimh_pkg::PH_REACH: begin
                            if (cur > $signed({1'b0, goal})) begin
                                st.phase = nimh_pkg::PH_MAINTAIN;
                                st.secs  = '0;
                                st.peak  = lo;
                                ra = nimh_pkg::RA_MAINTAIN;
                            end else begin
                                st.drive = drive_up(i_state.drive, 12'(nimh_pkg::REACH_STEP));
                                if (lo >= i_cfg.reach_max_voltage) begin
                                    st.phase = nimh_pkg::PH_RAMP_FAULT;
                                    ev = nimh_pkg::EV_FAIL;
                                end
                                ra = nimh_pkg::RA_REACH;
                            end
                        end
                        nimh_pkg::PH_MAINTAIN: begin
                            st.peak = peak_n;
                            if (lo > i_state.peak) begin
                                st.secs = '0;
                            end else if (i_state.last_sec != i_item.second_now) begin
                                st.last_sec = i_item.second_now;
                                if (i_state.secs != '1) begin
                                    st.secs = i_state.secs + 16'd1;
                                end
                            end
                            if (drop > i_cfg.drop_threshold) begin
                                st.phase = nimh_pkg::PH_DONE;
                                ev = nimh_pkg::EV_DONE;
                            end else if ({1'b0, h_diff} >
                                         ({1'b0, goal} + 13'(nimh_pkg::GOAL_HI_MARGIN))) begin
                                st.drive = (i_state.drive > 12'(nimh_pkg::REACH_STEP)) ?
                                           (i_state.drive - 12'(nimh_pkg::REACH_STEP)) : 12'd0;
                            end else if (({1'b0, h_diff} + 13'(nimh_pkg::GOAL_LO_MARGIN)) <
                                         {1'b0, goal}) begin
                                if (i_state.drive < 12'(nimh_pkg::DRIVE_CAP)) begin
                                    st.drive = drive_up(i_state.drive, comp_inc);
                                end
                                if (lo >= i_cfg.reach_max_voltage) begin
                                    st.phase = nimh_pkg::PH_MAINT_FAULT;
                                    ev = nimh_pkg::EV_FAIL;
                                end
                            end else if (st.secs >= i_cfg.peak_timeout_secs) begin
                                st.phase = nimh_pkg::PH_MAINT_FAULT;
                                ev = nimh_pkg::EV_FAIL;
                            end
                            if ((cand > i_state.level) && (ev == nimh_pkg::EV_NONE)) begin
                                st.level = cand;
                                ev = nimh_pkg::EV_LEVEL;
                            end
                            ra = nimh_pkg::RA_MAINTAIN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase

        o_state = st;
        o_result.phase            = st.phase;
        o_result.stepdown_setting = st.drive;
        o_result.charge_enable    = (st.phase == nimh_pkg::PH_RAMP) ||
                                    (st.phase == nimh_pkg::PH_REACH) ||
                                    (st.phase == nimh_pkg::PH_MAINTAIN);
        o_result.event_code       = ev;
        o_result.battery_level    = st.level;
        o_result.timer_rearm      = ra;
        o_result.sense_current    = show_sense ? cur : 13'sd0;
        o_result.sense_vbat       = show_sense ? lo : 12'd0;
    end

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;

    localparam int STUCK_LIMIT = 2000;

    localparam nimh_pkg::t_cfg CFG_DEFAULT = '{
        start_voltage: 12'd1500, ramp_end_current: 12'd50, ramp_max_voltage: 12'd3000,
        goal_half_c: 12'd300, goal_two_thirds_c: 12'd400, reach_max_voltage: 12'd3000,
        drop_threshold: 12'd8, peak_timeout_secs: 16'd1200
    };

    typedef struct {
        logic [1:0]  action;
        logic        rate;
        logic [11:0] hi;
        logic [11:0] lo;
        logic        tick;
        logic [5:0]  sec;
    } t_req;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_index = '0;
    logic [15:0] i_cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [nimh_pkg::IN_W-1:0] s_axis_tdata = '0;
    logic [1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [nimh_pkg::OUT_W-1:0] m_axis_tdata;

    nimh_charge_controller_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // charger shadow state
    nimh_pkg::t_cfg   cfg_sh = CFG_DEFAULT;
    nimh_pkg::t_phase ph_sh = nimh_pkg::PH_IDLE;
    bit               rate_sh = 1'b0;
    int               drive_sh = 0;
    int               peak_sh = 0;
    int               secs_sh = 0;
    logic [5:0]       last_sec_sh = '0;
    int               level_sh = 0;

    t_req              queued_cmds[$];
    nimh_pkg::t_result awaited[$];
    int      made_cnt = 0;
    int      mismatch_cnt = 0;
    int      cyc = 0;
    int      stuck_cycles = 0;
    int      gap_cnt = 0;
    int      stall_cnt = 0;
    bit      in_taken = 1'b0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int sat_raise(input int v, input int inc);
        return (v + inc > int'(nimh_pkg::DRIVE_MAX)) ? int'(nimh_pkg::DRIVE_MAX) : v + inc;
    endfunction

    function automatic int clip12(input int v);
        return (v < 0) ? 0 : ((v > 4095) ? 4095 : v);
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (cyc % 1024 < 150 || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    task automatic charge_step(input t_req rq, output nimh_pkg::t_result res);
        int hi, lo, cur, goal, h, diff, comp, cand;
        int ramp_end, ramp_max, reach_max, drop, timeout;
        nimh_pkg::t_event ev;
        nimh_pkg::t_rearm ra;
        hi = int'(rq.hi);
        lo = int'(rq.lo);
        cur = 0;
        ev = nimh_pkg::EV_NONE;
        ra = nimh_pkg::RA_NONE;
        ramp_end = int'(cfg_sh.ramp_end_current);
        ramp_max = int'(cfg_sh.ramp_max_voltage);
        reach_max = int'(cfg_sh.reach_max_voltage);
        drop = int'(cfg_sh.drop_threshold);
        timeout = int'(cfg_sh.peak_timeout_secs);
        res.sense_vbat = '0;
        if (rq.action == nimh_pkg::ACT_START) begin
            drive_sh = int'(cfg_sh.start_voltage);
            ph_sh = nimh_pkg::PH_RAMP;
            rate_sh = rq.rate;
            level_sh = 0;
            ra = nimh_pkg::RA_START;
            secs_sh = 0;
            peak_sh = 0;
        end else if (rq.action == nimh_pkg::ACT_STOP) begin
            if (ph_sh == nimh_pkg::PH_RAMP || ph_sh == nimh_pkg::PH_REACH ||
                ph_sh == nimh_pkg::PH_MAINTAIN)
                ph_sh = nimh_pkg::PH_IDLE;
        end else if (rq.action == nimh_pkg::ACT_SAMPLE) begin
            goal = rate_sh ? int'(cfg_sh.goal_two_thirds_c) : int'(cfg_sh.goal_half_c);
            cur = hi - lo;
            res.sense_vbat = rq.lo;
            if (ph_sh == nimh_pkg::PH_RAMP && rq.tick) begin
                if (cur > ramp_end) begin
                    ph_sh = nimh_pkg::PH_REACH;
                    ra = nimh_pkg::RA_REACH;
                end else begin
                    drive_sh = sat_raise(drive_sh, int'(nimh_pkg::START_STEP));
                    if (lo >= ramp_max) begin
                        ph_sh = nimh_pkg::PH_RAMP_FAULT;
                        ev = nimh_pkg::EV_FAIL;
                    end
                end
            end else if (ph_sh == nimh_pkg::PH_REACH && rq.tick) begin
                if (cur > goal) begin
                    ph_sh = nimh_pkg::PH_MAINTAIN;
                    secs_sh = 0;
                    peak_sh = lo;
                    ra = nimh_pkg::RA_MAINTAIN;
                end else begin
                    drive_sh = sat_raise(drive_sh, int'(nimh_pkg::REACH_STEP));
                    if (lo >= reach_max) begin
                        ph_sh = nimh_pkg::PH_RAMP_FAULT;
                        ev = nimh_pkg::EV_FAIL;
                    end
                    ra = nimh_pkg::RA_REACH;
                end
            end else if (ph_sh == nimh_pkg::PH_MAINTAIN && rq.tick) begin
                if (lo > peak_sh) begin
                    peak_sh = lo;
                    secs_sh = 0;
                end else if (last_sec_sh != rq.sec) begin
                    last_sec_sh = rq.sec;
                    if (secs_sh < 65535) secs_sh++;
                end
                h = (hi < lo) ? lo : hi;
                diff = h - lo;
                if (peak_sh - lo > drop) begin
                    ph_sh = nimh_pkg::PH_DONE;
                    ev = nimh_pkg::EV_DONE;
                end else if (diff > goal + int'(nimh_pkg::GOAL_HI_MARGIN)) begin
                    drive_sh = (drive_sh > int'(nimh_pkg::REACH_STEP)) ?
                               drive_sh - int'(nimh_pkg::REACH_STEP) : 0;
                end else if (diff < goal - int'(nimh_pkg::GOAL_LO_MARGIN)) begin
                    comp = goal - diff;
                    if (drive_sh < int'(nimh_pkg::DRIVE_CAP))
                        drive_sh = sat_raise(drive_sh, (comp * int'(nimh_pkg::COMP_GAIN)) >>
                                                       nimh_pkg::COMP_SHIFT);
                    if (lo >= reach_max) begin
                        ph_sh = nimh_pkg::PH_MAINT_FAULT;
                        ev = nimh_pkg::EV_FAIL;
                    end
                end else if (secs_sh >= timeout) begin
                    ph_sh = nimh_pkg::PH_MAINT_FAULT;
                    ev = nimh_pkg::EV_FAIL;
                end
                cand = 0;
                for (int i = 0; i < nimh_pkg::LEVEL_COUNT; i++)
                    if (lo > int'(nimh_pkg::LEVEL_THR[i])) cand = i;
                if (cand > level_sh && ev == nimh_pkg::EV_NONE) begin
                    level_sh = cand;
                    ev = nimh_pkg::EV_LEVEL;
                end
                ra = nimh_pkg::RA_MAINTAIN;
            end
        end
        res.phase = ph_sh;
        res.stepdown_setting = drive_sh[11:0];
        res.charge_enable = (ph_sh == nimh_pkg::PH_RAMP || ph_sh == nimh_pkg::PH_REACH ||
                             ph_sh == nimh_pkg::PH_MAINTAIN);
        res.event_code = ev;
        res.battery_level = level_sh[nimh_pkg::LEVEL_W-1:0];
        res.timer_rearm = ra;
        res.sense_current = cur[12:0];
    endtask

    task automatic push_req(input logic [1:0] act, input bit rate, input int hi, input int lo,
                            input bit tick, input int sec);
        t_req r;
        r.action = act;
        r.rate = rate;
        r.hi = hi[11:0];
        r.lo = lo[11:0];
        r.tick = tick;
        r.sec = sec[5:0];
        queued_cmds.push_back(r);
        made_cnt++;
    endtask

    task automatic push_noise();
        push_req(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom_range(0, 4095),
                 $urandom_range(0, 4095), 1'($urandom_range(0, 1)), $urandom_range(0, 63));
    endtask

    // one start, a run of samples shaped to walk the phases with random items mixed in, maybe a stop
    task automatic charge_session();
        int n, vb, cur, goal, sec, pick;
        bit rate;
        rate = 1'($urandom_range(0, 1));
        goal = rate ? int'(cfg_sh.goal_two_thirds_c) : int'(cfg_sh.goal_half_c);
        sec = $urandom_range(0, 59);
        push_req(nimh_pkg::ACT_START, rate, $urandom_range(0, 4095), $urandom_range(0, 4095),
                 1'($urandom_range(0, 1)), sec);
        n = $urandom_range(4, 60);
        vb = ($urandom_range(0, 9) != 0) ? $urandom_range(2200, 2750) : $urandom_range(0, 4095);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 19) == 0) begin
                push_noise();
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    vb = vb + $urandom_range(0, 3);
                else if (pick >= 80 && pick < 94)
                    vb = vb - $urandom_range(0, int'(cfg_sh.drop_threshold) + 6);
                else if (pick >= 94)
                    vb = $urandom_range(0, 4095);
                vb = clip12(vb);
                pick = $urandom_range(0, 9);
                if (pick < 3)
                    cur = $urandom_range(0, int'(cfg_sh.ramp_end_current));
                else if (pick < 8)
                    cur = goal + $urandom_range(0, 24) - 12;
                else if (pick == 8)
                    cur = $urandom_range(0, 4095);
                else
                    cur = -int'($urandom_range(0, 60));
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    sec = (sec + 1) % 60;
                else if (pick == 9)
                    sec = $urandom_range(0, 63);
                push_req(nimh_pkg::ACT_SAMPLE, 1'($urandom_range(0, 1)), clip12(vb + cur), vb,
                         $urandom_range(0, 7) != 0, sec);
            end
        end
        if ($urandom_range(0, 1))
            push_req(nimh_pkg::ACT_STOP, 1'($urandom_range(0, 1)), $urandom_range(0, 4095),
                     $urandom_range(0, 4095), 1'($urandom_range(0, 1)), sec);
    endtask

    task automatic random_charge(input int n);
        int stop_at;
        stop_at = made_cnt + n;
        while (made_cnt < stop_at) charge_session();
    endtask

    // walks the default settings through every phase but PH_MAINT_FAULT, and through corners
    task automatic directed_items();
        push_req(nimh_pkg::ACT_SAMPLE, 1, 4095, 0, 1, 0);
        push_req(nimh_pkg::ACT_STOP, 1, 4095, 4095, 1, 1);
        push_req(2'd3, 1, 4095, 4095, 1, 63);
        push_req(nimh_pkg::ACT_START, 0, 1234, 567, 1, 2);
        push_req(nimh_pkg::ACT_SAMPLE, 0, 1000, 1000, 0, 3);
        push_req(nimh_pkg::ACT_SAMPLE, 0, 1000, 1000, 1, 4);
        push_req(nimh_pkg::ACT_SAMPLE, 0, 2100, 2000, 1, 5);
        push_req(nimh_pkg::ACT_SAMPLE, 0, 2200, 2000, 1, 6);
        push_req(nimh_pkg::ACT_SAMPLE, 0, 2350, 2000, 1, 7);
        push_req(nimh_pkg::ACT_SAMPLE, 0, 1900, 2000, 1, 8);
        push_req(nimh_pkg::ACT_SAMPLE, 0, 2750, 2450, 1, 9);
        push_req(nimh_pkg::ACT_SAMPLE, 0, 2740, 2440, 1, 10);
        push_req(nimh_pkg::ACT_STOP, 0, 0, 0, 0, 11);
        push_req(nimh_pkg::ACT_START, 1, 0, 0, 0, 12);
        push_req(nimh_pkg::ACT_SAMPLE, 1, 3000, 3000, 1, 13);
        push_req(nimh_pkg::ACT_START, 1, 0, 0, 0, 14);
        push_req(nimh_pkg::ACT_SAMPLE, 1, 3100, 3000, 1, 15);
        push_req(nimh_pkg::ACT_SAMPLE, 1, 3000, 3000, 1, 16);
        push_req(nimh_pkg::ACT_START, 0, 0, 0, 0, 17);
        push_req(nimh_pkg::ACT_SAMPLE, 0, 2400, 2300, 1, 18);
        push_req(nimh_pkg::ACT_SAMPLE, 0, 2700, 2300, 1, 19);
        push_req(nimh_pkg::ACT_SAMPLE, 0, 2600, 2300, 1, 60);
        push_req(nimh_pkg::ACT_START, 1, 0, 0, 0, 61);
        push_req(nimh_pkg::ACT_STOP, 1, 0, 0, 0, 62);
    endtask

    task automatic apply_cfg(input nimh_pkg::t_cfg c);
        logic [15:0] v;
        for (int k = 0; k < 8; k++) begin
            case (nimh_pkg::t_cfg_idx'(k))
                nimh_pkg::CFG_START_VOLTAGE:  v = 16'(c.start_voltage);
                nimh_pkg::CFG_RAMP_END_CUR:   v = 16'(c.ramp_end_current);
                nimh_pkg::CFG_RAMP_MAX_VOLT:  v = 16'(c.ramp_max_voltage);
                nimh_pkg::CFG_GOAL_HALF_C:    v = 16'(c.goal_half_c);
                nimh_pkg::CFG_GOAL_2_3_C:     v = 16'(c.goal_two_thirds_c);
                nimh_pkg::CFG_REACH_MAX_VOLT: v = 16'(c.reach_max_voltage);
                nimh_pkg::CFG_DROP_THRESHOLD: v = 16'(c.drop_threshold);
                default:                      v = c.peak_timeout_secs;
            endcase
            @(negedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_index <= nimh_pkg::t_cfg_idx'(k);
            i_cfg_wdata <= v;
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_sh = c;
    endtask

    task automatic wait_idle();
        while (queued_cmds.size() != 0 || s_axis_tvalid || awaited.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        nimh_pkg::t_cfg c;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        directed_items();
        random_charge(300);
        wait_idle();

        c = '0;
        apply_cfg(c);
        random_charge(250);
        wait_idle();

        c = '{start_voltage: 12'hFFF, ramp_end_current: 12'hFFF, ramp_max_voltage: 12'hFFF,
              goal_half_c: 12'hFFF, goal_two_thirds_c: 12'hFFF, reach_max_voltage: 12'hFFF,
              drop_threshold: 12'hFFF, peak_timeout_secs: 16'hFFFF};
        apply_cfg(c);
        random_charge(200);
        wait_idle();

        repeat (3) begin
            c.start_voltage = 12'($urandom_range(0, 4095));
            c.ramp_end_current = 12'($urandom_range(0, 200));
            c.ramp_max_voltage = 12'($urandom_range(2600, 4095));
            c.goal_half_c = 12'($urandom_range(0, 600));
            c.goal_two_thirds_c = 12'($urandom_range(0, 800));
            c.reach_max_voltage = 12'($urandom_range(2600, 4095));
            c.drop_threshold = 12'($urandom_range(0, 30));
            c.peak_timeout_secs = 16'($urandom_range(0, 20));
            apply_cfg(c);
            random_charge(300);
            wait_idle();
        end

        c = CFG_DEFAULT;
        c.peak_timeout_secs = 16'd3;
        c.start_voltage = 12'd4090;
        apply_cfg(c);
        random_charge(250);
        wait_idle();

        if (mismatch_cnt == 0 && awaited.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
    end

    // request side
    always @(negedge i_clk) begin
        t_req nx;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (gap_cnt > 0) begin
                gap_cnt = gap_cnt - 1;
                s_axis_tvalid <= 1'b0;
            end else if (queued_cmds.size() != 0) begin
                nx = queued_cmds.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {nx.sec, nx.tick, nx.lo, nx.hi, nx.rate};
                s_axis_tuser <= nx.action;
                gap_cnt = idle_len();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_cnt > 0) begin
            stall_cnt = stall_cnt - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            stall_cnt = idle_len();
        end
    end

    always @(posedge i_clk) begin
        t_req rq;
        nimh_pkg::t_result want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                rq.action = s_axis_tuser;
                rq.rate = s_axis_tdata[0];
                rq.hi = s_axis_tdata[12:1];
                rq.lo = s_axis_tdata[24:13];
                rq.tick = s_axis_tdata[25];
                rq.sec = s_axis_tdata[31:26];
                charge_step(rq, want);
                awaited.push_back(want);
            end
        end
    end

    // result side
    always @(posedge i_clk) begin
        nimh_pkg::t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.phase = nimh_pkg::t_phase'(m_axis_tdata[2:0]);
            got.stepdown_setting = m_axis_tdata[14:3];
            got.charge_enable = m_axis_tdata[15];
            got.event_code = nimh_pkg::t_event'(m_axis_tdata[17:16]);
            got.battery_level = m_axis_tdata[21:18];
            got.timer_rearm = nimh_pkg::t_rearm'(m_axis_tdata[23:22]);
            got.sense_current = m_axis_tdata[36:24];
            got.sense_vbat = m_axis_tdata[48:37];
            if (awaited.size() == 0) begin
                if (mismatch_cnt < 10)
                    $display("%0t: result with no request pending: tdata %h", $realtime,
                             m_axis_tdata);
                mismatch_cnt <= mismatch_cnt + 1;
            end else begin
                want = awaited.pop_front();
                if (got.phase !== want.phase ||
                    got.stepdown_setting !== want.stepdown_setting ||
                    got.charge_enable !== want.charge_enable ||
                    got.event_code !== want.event_code ||
                    got.battery_level !== want.battery_level ||
                    got.timer_rearm !== want.timer_rearm ||
                    got.sense_current !== want.sense_current ||
                    got.sense_vbat !== want.sense_vbat) begin
                    if (mismatch_cnt < 10) begin
                        $display("%0t exp ph %0d sd %0d en %0d ev %0d lv %0d ra %0d i %0d v %0d",
                                 $realtime, want.phase, want.stepdown_setting,
                                 want.charge_enable, want.event_code, want.battery_level,
                                 want.timer_rearm, want.sense_current, want.sense_vbat);
                        $display("%0t got ph %0d sd %0d en %0d ev %0d lv %0d ra %0d i %0d v %0d",
                                 $realtime, got.phase, got.stepdown_setting,
                                 got.charge_enable, got.event_code, got.battery_level,
                                 got.timer_rearm, got.sense_current, got.sense_vbat);
                    end
                    mismatch_cnt <= mismatch_cnt + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
